### hdl/ptb_pkg.sv
// periodic timer bank: shared types, constants and sizes
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int COUNT_BITS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int TIDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_ARM    = 2'd1,
        KIND_DISARM = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ARM,
        OP_DISARM
    } t_op;

    localparam logic RK_EXPIRY = 1'b0;
    localparam logic RK_DISARM = 1'b1;

    typedef struct packed {
        t_op                   op;
        logic                  in_range;
        logic [3:0]            idx;
        logic [COUNT_BITS-1:0] start;
        logic [COUNT_BITS-1:0] interval;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    typedef struct packed {
        logic       result_kind;
        logic [3:0] timer_id;
        logic       was_armed;
        logic       last;
    } t_rsp;

    typedef struct packed {
        logic push;
        t_rsp rsp;
    } t_rsp_req;

endpackage

`default_nettype wire

### hdl/ptb_front.sv
// front end: request intake, classification and command queue
`timescale 1ns / 1ps
`default_nettype none

module ptb_front
    import ptb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_kind,
    input  wire logic [3:0]  i_timer_index,
    input  wire logic [15:0] i_start_count,
    input  wire logic [15:0] i_reload_interval,
    input  wire logic        i_pop,
    output t_cmd_head        o_head
);

    t_cmd              r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    t_cmd w_cmd;
    logic w_keep;
    logic w_wr;
    logic w_rd;

    always_comb begin
        w_cmd.in_range = (32'(i_timer_index) < NUM_TIMERS);
        w_cmd.idx      = i_timer_index;
        w_cmd.start    = COUNT_BITS'(i_start_count);
        w_cmd.interval = COUNT_BITS'(i_reload_interval);
        w_cmd.op       = OP_TICK;
        w_keep         = 1'b0;
        unique case (i_kind)
            KIND_TICK: begin
                w_cmd.op = OP_TICK;
                w_keep   = 1'b1;
            end
            KIND_ARM: begin
                w_cmd.op = OP_ARM;
                w_keep   = w_cmd.in_range;
            end
            KIND_DISARM: begin
                w_cmd.op = OP_DISARM;
                w_keep   = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_full       = (r_cnt == QCNT_W'(Q_DEPTH));
    assign w_wr         = i_push && !o_full && w_keep;
    assign w_rd         = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_rd) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(w_wr) - QCNT_W'(w_rd);
        end
    end

endmodule

`default_nettype wire

### hdl/ptb_back.sv
// back end: timer bank and command sequencer
`timescale 1ns / 1ps
`default_nettype none

module ptb_back
    import ptb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd_head i_head,
    output logic           o_pop,
    input  wire logic      i_rsp_full,
    output t_rsp_req       o_rsp_req
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    logic [COUNT_BITS-1:0] r_count  [NUM_TIMERS];
    logic [COUNT_BITS-1:0] r_reload [NUM_TIMERS];

    t_state            r_state,   n_state;
    logic [TIDX_W-1:0] r_scan,    n_scan;
    logic [NCNT_W-1:0] r_n,       n_n;
    logic              r_pend,    n_pend;
    logic [3:0]        r_pend_id, n_pend_id;

    logic [31:0]           w_idx_ext;
    logic [TIDX_W-1:0]     w_addr;
    logic [COUNT_BITS-1:0] w_cur;
    logic [COUNT_BITS-1:0] w_cur_rel;
    logic                  w_expire;
    logic                  w_record;
    logic                  w_we;
    logic [COUNT_BITS-1:0] w_wcount;
    logic [COUNT_BITS-1:0] w_wreload;

    assign w_idx_ext = 32'(i_head.cmd.idx);
    assign w_addr    = (r_state == S_SCAN) ? r_scan : w_idx_ext[TIDX_W-1:0];
    assign w_cur     = r_count[w_addr];
    assign w_cur_rel = r_reload[w_addr];
    assign w_expire  = (r_state == S_SCAN) && (w_cur == COUNT_BITS'(1));
    assign w_record  = w_expire && (r_n < NCNT_W'(MAX_RESULTS));

    always_comb begin
        n_state   = r_state;
        n_scan    = r_scan;
        n_n       = r_n;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        o_pop     = 1'b0;
        o_rsp_req = '0;
        w_we      = 1'b0;
        w_wcount  = w_cur;
        w_wreload = w_cur_rel;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.cmd.op)
                        OP_ARM: begin
                            o_pop     = 1'b1;
                            w_we      = 1'b1;
                            w_wcount  = i_head.cmd.start;
                            w_wreload = i_head.cmd.interval;
                        end
                        OP_DISARM: begin
                            if (!i_rsp_full) begin
                                o_pop                     = 1'b1;
                                o_rsp_req.push            = 1'b1;
                                o_rsp_req.rsp.result_kind = RK_DISARM;
                                o_rsp_req.rsp.timer_id    = i_head.cmd.idx;
                                o_rsp_req.rsp.was_armed   = i_head.cmd.in_range &&
                                                            (w_cur != '0);
                                o_rsp_req.rsp.last        = 1'b1;
                                w_we                      = i_head.cmd.in_range;
                                w_wcount                  = '0;
                                w_wreload                 = '0;
                            end
                        end
                        OP_TICK: begin
                            o_pop   = 1'b1;
                            n_scan  = TIDX_W'(NUM_TIMERS - 1);
                            n_n     = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!(w_record && r_pend && i_rsp_full)) begin
                    if (w_cur != '0) begin
                        w_we     = 1'b1;
                        w_wcount = w_expire ? w_cur_rel : (w_cur - COUNT_BITS'(1));
                    end
                    if (w_record) begin
                        if (r_pend) begin
                            o_rsp_req.push            = 1'b1;
                            o_rsp_req.rsp.result_kind = RK_EXPIRY;
                            o_rsp_req.rsp.timer_id    = r_pend_id;
                            o_rsp_req.rsp.was_armed   = 1'b0;
                            o_rsp_req.rsp.last        = 1'b0;
                        end
                        n_pend    = 1'b1;
                        n_pend_id = 4'(r_scan);
                        n_n       = r_n + NCNT_W'(1);
                    end
                    if (r_scan == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_scan = r_scan - TIDX_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_pend) begin
                    n_state = S_IDLE;
                end else if (!i_rsp_full) begin
                    o_rsp_req.push            = 1'b1;
                    o_rsp_req.rsp.result_kind = RK_EXPIRY;
                    o_rsp_req.rsp.timer_id    = r_pend_id;
                    o_rsp_req.rsp.was_armed   = 1'b0;
                    o_rsp_req.rsp.last        = 1'b1;
                    n_pend                    = 1'b0;
                    n_state                   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_scan    <= '0;
            r_n       <= '0;
            r_pend    <= 1'b0;
            r_pend_id <= '0;
        end else begin
            r_state   <= n_state;
            r_scan    <= n_scan;
            r_n       <= n_n;
            r_pend    <= n_pend;
            r_pend_id <= n_pend_id;
        end
    end

    // timer bank, one write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_count[i]  <= '0;
                r_reload[i] <= '0;
            end
        end else if (w_we) begin
            r_count[w_addr]  <= w_wcount;
            r_reload[w_addr] <= w_wreload;
        end
    end

endmodule

`default_nettype wire

### hdl/ptb_rsp_q.sv
// result queue between the sequencer and the result side
`timescale 1ns / 1ps
`default_nettype none

module ptb_rsp_q
    import ptb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_rsp_req i_req,
    output logic          o_full,
    output logic          o_empty,
    input  wire logic     i_pop,
    output t_rsp          o_rsp
);

    t_rsp              r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rsp   = r_q[r_rptr];
    assign w_wr    = i_req.push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wptr] <= i_req.rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_rd) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(w_wr) - QCNT_W'(w_rd);
        end
    end

endmodule

`default_nettype wire

### hdl/periodic_timer_bank.sv
// periodic timer bank top level: front end, sequencer and result queue
//
// channel   direction  handshake              payload
// request   in         push / full            kind, timer_index, start_count, reload_interval
// result    out        empty / pop            result_kind, timer_id, was_armed, last
//
// arm and disarm are handled from the idle state of the sequencer; a tick visits each timer,
// highest first, one per cycle through the single bank port while results can be queued
// a four-entry command queue takes requests while the sequencer is busy
// results wait in a four-entry queue; when it is full the sequencer holds its place
// synchronous active-low reset clears all timers and both queues at once
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_bank
    import ptb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_kind,
    input  wire logic [3:0]  i_timer_index,
    input  wire logic [15:0] i_start_count,
    input  wire logic [15:0] i_reload_interval,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_result_kind,
    output logic [3:0]       o_timer_id,
    output logic             o_was_armed,
    output logic             o_last
);

    t_cmd_head w_head;
    logic      w_cmd_pop;
    t_rsp_req  w_rsp_req;
    logic      w_rsp_full;
    t_rsp      w_rsp;

    ptb_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_kind            (i_kind),
        .i_timer_index     (i_timer_index),
        .i_start_count     (i_start_count),
        .i_reload_interval (i_reload_interval),
        .i_pop             (w_cmd_pop),
        .o_head            (w_head)
    );

    ptb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_cmd_pop),
        .i_rsp_full (w_rsp_full),
        .o_rsp_req  (w_rsp_req)
    );

    ptb_rsp_q u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rsp_req),
        .o_full  (w_rsp_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_rsp   (w_rsp)
    );

    assign o_result_kind = w_rsp.result_kind;
    assign o_timer_id    = w_rsp.timer_id;
    assign o_was_armed   = w_rsp.was_armed;
    assign o_last        = w_rsp.last;

    a_no_rsp_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_rsp_req.push && w_rsp_full))
        else $error("result pushed into a full queue");

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_head.valid)
        else $error("command taken from an empty queue");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp_req.push |=> !empty)
        else $error("pushed result not visible");

endmodule

`default_nettype wire

### tb/sv/periodic_timer_bank_tb.sv
// periodic timer bank testbench: directed and random requests checked against a timer shadow
`timescale 1ns / 1ps

module periodic_timer_bank_tb;
    import ptb_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    class timer_shadow;
        logic [COUNT_BITS-1:0] down_count [NUM_TIMERS];
        logic [COUNT_BITS-1:0] reload_value [NUM_TIMERS];
        t_rsp awaited [$];
        int unsigned errors;

        function void clear_timers();
            for (int i = 0; i < NUM_TIMERS; i++) begin
                down_count[i] = '0;
                reload_value[i] = '0;
            end
            awaited.delete();
            errors = 0;
        endfunction

        function void note_request(logic [1:0] kind, logic [3:0] idx,
                                   logic [15:0] start, logic [15:0] interval);
            t_rsp batch [$];
            t_rsp r;
            int n;
            n = 0;
            if (kind == KIND_ARM) begin
                if (32'(idx) < NUM_TIMERS) begin
                    down_count[idx] = start[COUNT_BITS-1:0];
                    reload_value[idx] = interval[COUNT_BITS-1:0];
                end
            end else if (kind == KIND_DISARM) begin
                r.result_kind = RK_DISARM;
                r.timer_id = idx;
                r.was_armed = 1'b0;
                r.last = 1'b1;
                if (32'(idx) < NUM_TIMERS) begin
                    r.was_armed = (down_count[idx] != '0);
                    down_count[idx] = '0;
                    reload_value[idx] = '0;
                end
                awaited.push_back(r);
            end else if (kind == KIND_TICK) begin
                for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
                    if (down_count[i] == COUNT_BITS'(1)) begin
                        down_count[i] = reload_value[i];
                        if (n < MAX_RESULTS) begin
                            r.result_kind = RK_EXPIRY;
                            r.timer_id = i[3:0];
                            r.was_armed = 1'b0;
                            r.last = 1'b0;
                            batch.push_back(r);
                            n++;
                        end
                    end else if (down_count[i] != '0) begin
                        down_count[i] = down_count[i] - COUNT_BITS'(1);
                    end
                end
                if (n > 0) begin
                    batch[n-1].last = 1'b1;
                end
                foreach (batch[k]) begin
                    awaited.push_back(batch[k]);
                end
            end
        endfunction

        function void report_field(string name, logic [3:0] exp_v, logic [3:0] got_v);
            if (exp_v !== got_v) begin
                $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp_r;
            if (awaited.size() == 0) begin
                $display("%0t unexpected result: expected none actual %p", $time, got);
                errors++;
            end else begin
                exp_r = awaited.pop_front();
                report_field("result_kind", 4'(exp_r.result_kind), 4'(got.result_kind));
                report_field("timer_id", exp_r.timer_id, got.timer_id);
                report_field("was_armed", 4'(exp_r.was_armed), 4'(got.was_armed));
                report_field("last", 4'(exp_r.last), 4'(got.last));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_kind;
    logic [3:0]  i_timer_index;
    logic [15:0] i_start_count;
    logic [15:0] i_reload_interval;
    logic        empty;
    logic        pop;
    logic        o_result_kind;
    logic [3:0]  o_timer_id;
    logic        o_was_armed;
    logic        o_last;

    timer_shadow shadow;
    int unsigned idle_pct;
    int unsigned stall_pct;

    periodic_timer_bank dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_kind            (i_kind),
        .i_timer_index     (i_timer_index),
        .i_start_count     (i_start_count),
        .i_reload_interval (i_reload_interval),
        .empty             (empty),
        .pop               (pop),
        .o_result_kind     (o_result_kind),
        .o_timer_id        (o_timer_id),
        .o_was_armed       (o_was_armed),
        .o_last            (o_last)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver side
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rsp got;
        if (i_rst_n && pop && !empty) begin
            got.result_kind = o_result_kind;
            got.timer_id = o_timer_id;
            got.was_armed = o_was_armed;
            got.last = o_last;
            shadow.check_result(got);
        end
    end

    task automatic send_request(logic [1:0] kind, logic [3:0] idx,
                                logic [15:0] start, logic [15:0] interval);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_kind <= kind;
        i_timer_index <= idx;
        i_start_count <= start;
        i_reload_interval <= interval;
        do @(posedge i_clk); while (full);
        shadow.note_request(kind, idx, start, interval);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (shadow.awaited.size() > 0) @(posedge i_clk);
    endtask

    // mostly short arms and ticks so that timers expire often
    task automatic random_requests(int unsigned count);
        int unsigned done;
        int unsigned pick;
        logic [1:0]  kind;
        logic [15:0] start;
        logic [15:0] interval;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            start = 16'($urandom_range(65535));
            interval = 16'($urandom_range(65535));
            if (pick < 50) begin
                kind = KIND_TICK;
            end else if (pick < 80) begin
                kind = KIND_ARM;
                if ($urandom_range(99) < 85) start = 16'($urandom_range(6));
                if ($urandom_range(99) < 85) interval = 16'($urandom_range(4));
            end else if (pick < 95) begin
                kind = KIND_DISARM;
            end else begin
                kind = KIND_UNUSED;
            end
            send_request(kind, 4'($urandom_range(15)), start, interval);
            if (kind != KIND_UNUSED) done++;
        end
    endtask

    initial begin
        shadow = new();
        shadow.clear_timers();
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_kind = KIND_TICK;
        i_timer_index = '0;
        i_start_count = '0;
        i_reload_interval = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one-shot, extremes, periodic, idle arm, unused kind, full expiry burst
        send_request(KIND_ARM, 4'd0, 16'd1, 16'd0);
        send_request(KIND_ARM, 4'd15, 16'hFFFF, 16'hFFFF);
        send_request(KIND_ARM, 4'd5, 16'd2, 16'd1);
        send_request(KIND_ARM, 4'd3, 16'd0, 16'hFFFF);
        send_request(KIND_TICK, 4'hF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_TICK, 4'd0, 16'd0, 16'd0);
        send_request(KIND_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_DISARM, 4'd15, 16'd0, 16'd0);
        send_request(KIND_DISARM, 4'd0, 16'hFFFF, 16'hFFFF);
        send_request(KIND_TICK, 4'd7, 16'h1234, 16'h4321);
        for (int i = 0; i < NUM_TIMERS; i++) begin
            send_request(KIND_ARM, i[3:0], 16'd1, 16'd1);
        end
        send_request(KIND_TICK, 4'd0, 16'd0, 16'd0);
        send_request(KIND_TICK, 4'd0, 16'd0, 16'd0);
        wait_drained();

        random_requests(43);
        wait_drained();
        idle_pct = 59;
        random_requests(43);
        wait_drained();
        idle_pct = 0;
        stall_pct = 59;
        random_requests(43);
        wait_drained();
        idle_pct = 32;
        stall_pct = 32;
        random_requests(43);
        wait_drained();

        stall_pct = 0;
        repeat (4 * (NUM_TIMERS + 2)) @(posedge i_clk);
        if (shadow.awaited.size() != 0) begin
            $display("%0t results missing: expected %0d more actual 0", $time,
                     shadow.awaited.size());
            shadow.errors++;
        end
        if (shadow.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
